@@ hdl/ppbp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppbp_pkg
// Shared widths, command codes, control records and arithmetic helpers for
// the path-based perceptron branch predictor.
// ----------------------------------------------------------------------------
package ppbp_pkg;

  // Default geometry.
  localparam int HISTORY_LENGTH_DEF = 15;
  localparam int NUM_ROWS_DEF       = 64;
  localparam int ADDR_SHIFT_DEF     = 2;

  // Fixed field widths.
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 48;
  localparam int SUM_W    = 12;
  localparam int WGT_W    = 8;
  localparam int THRESH_W = 12;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Training threshold after reset.
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd54;

  // Register addresses.
  localparam logic [PADDR_W-1:0] REG_THRESHOLD = 3'd0;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PREDICT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNCOND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SQUASH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BTBMISS = 3'd4;

  // Saturation limits.
  localparam logic signed [SUM_W+1:0] SUM_MAX = 14'sd2047;
  localparam logic signed [SUM_W+1:0] SUM_MIN = -14'sd2048;
  localparam logic signed [WGT_W-1:0] WGT_MAX = 8'sd127;
  localparam logic signed [WGT_W-1:0] WGT_MIN = -8'sd128;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic rd_train;
    logic wr_train;
    logic clear_wr;
    logic out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic train_req;
    logic clear_last;
  } stat_t;

  // Clamp a widened sum into the signed 12-bit range.
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W+1:0] c;
    begin
      c = v;
      if (v > SUM_MAX) begin
        c = SUM_MAX;
      end else if (v < SUM_MIN) begin
        c = SUM_MIN;
      end
      return c[SUM_W-1:0];
    end
  endfunction

  // One saturating training step of a weight.
  function automatic logic signed [WGT_W-1:0] step_weight(input logic signed [WGT_W-1:0] w,
                                                          input logic up);
    logic signed [WGT_W-1:0] r;
    begin
      r = w;
      if (up && (w != WGT_MAX)) begin
        r = w + 8'sd1;
      end else if (!up && (w != WGT_MIN)) begin
        r = w - 8'sd1;
      end
      return r;
    end
  endfunction

endpackage

@@ hdl/ppbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppbp_ctrl
// Sequencer of the predictor: clearing pass, table read, execution,
// training read-modify-write and hand-over to the output register.
// ----------------------------------------------------------------------------
module ppbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ppbp_pkg::stat_t stat,
  output ppbp_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_TRD   = 3'd4;
  localparam logic [2:0] S_TWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // The output register can take a result when empty or being emptied.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    ctrl          = '0;
    case (state)
      S_CLEAR: begin
        ctrl.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.train_req ? S_TRD : S_DONE;
      end
      S_TRD: begin
        ctrl.rd_train = 1'b1;
        state_next    = S_TWR;
      end
      S_TWR: begin
        ctrl.wr_train = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/ppbp_datapath.sv @@
// ----------------------------------------------------------------------------
// ppbp_datapath
// Weight banks (one for the bias and one per history position), running sums,
// histories, path and the result register of the predictor.
// ----------------------------------------------------------------------------
module ppbp_datapath #(
  parameter int HISTORY_LENGTH = ppbp_pkg::HISTORY_LENGTH_DEF,
  parameter int NUM_ROWS       = ppbp_pkg::NUM_ROWS_DEF,
  parameter int ADDR_SHIFT     = ppbp_pkg::ADDR_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ppbp_pkg::ctrl_t                    ctrl,
  output ppbp_pkg::stat_t                    stat,
  input  logic [ppbp_pkg::CMD_W-1:0]         command,
  input  logic [ppbp_pkg::ADDR_W-1:0]        pc_addr,
  input  logic                               taken,
  input  logic                               squashed,
  input  logic [ppbp_pkg::THRESH_W-1:0]      threshold,
  output logic                               predict_taken,
  output logic signed [ppbp_pkg::SUM_W-1:0]  perceptron_sum,
  output logic                               trained
);

  localparam int NW    = HISTORY_LENGTH + 1;
  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int LW    = $clog2(NW);
  localparam int PC_W  = $clog2(NW + 1);
  localparam int SW    = ppbp_pkg::SUM_W;
  localparam int WW    = ppbp_pkg::WGT_W;
  localparam logic [PC_W-1:0]  PC_FULL  = PC_W'(NW);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

  // Latched request.
  logic [ppbp_pkg::CMD_W-1:0] cmd_r;
  logic [ROW_W-1:0]           row_r;
  logic                       taken_r;
  logic                       sq_r;

  // Predictor state.
  logic signed [SW-1:0] spec_sums [NW];
  logic signed [SW-1:0] comm_sums [NW];
  logic [NW-1:0]        spec_hist;
  logic [NW-1:0]        comm_hist;
  logic [ROW_W-1:0]     path_rows [NW];
  logic [PC_W-1:0]      path_count;
  logic [ROW_W-1:0]     clear_cnt;

  // Training bookkeeping.
  logic [ROW_W-1:0]     train_addr [NW];
  logic [NW-1:0]        train_bits;

  // Result register and bank read data.
  logic                 res_pt;
  logic signed [SW-1:0] res_sum;
  logic                 res_tr;
  logic signed [WW-1:0] rdata [NW];

  // Combinational results of the execute step.
  logic signed [SW-1:0] y;
  logic [SW-1:0]        mag;
  logic                 pt;
  logic                 do_train;
  logic signed [SW-1:0] spec_adv [NW];
  logic signed [SW-1:0] comm_adv [NW];
  logic [NW-1:0]        comm_hist_new;
  logic [ROW_W-1:0]     slot_row [NW];
  logic [ROW_W-1:0]     row_in;

  assign row_in = ROW_W'(pc_addr >> ADDR_SHIFT);

  // Sum for predict and resolve, and the training decision.
  always_comb begin
    y        = ppbp_pkg::sat_sum((SW+2)'(spec_sums[NW-1]) + (SW+2)'(rdata[0]));
    pt       = !y[SW-1];
    mag      = y[SW-1] ? (SW)'(-y) : y;
    do_train = (cmd_r == ppbp_pkg::CMD_RESOLVE) && (sq_r || (mag <= threshold));
    comm_hist_new = {comm_hist[NW-2:0], taken_r};
  end

  assign stat.train_req  = do_train;
  assign stat.clear_last = (clear_cnt == ROW_LAST);

  // Advanced sums: each partial sum moves one place up by one weight.
  always_comb begin
    spec_adv[0] = '0;
    comm_adv[0] = '0;
    for (int i = 1; i < NW; i++) begin
      spec_adv[i] = ppbp_pkg::sat_sum(pt ?
                      (SW+2)'(spec_sums[i-1]) + (SW+2)'(rdata[NW-i]) :
                      (SW+2)'(spec_sums[i-1]) - (SW+2)'(rdata[NW-i]));
      comm_adv[i] = ppbp_pkg::sat_sum(taken_r ?
                      (SW+2)'(comm_sums[i-1]) + (SW+2)'(rdata[NW-i]) :
                      (SW+2)'(comm_sums[i-1]) - (SW+2)'(rdata[NW-i]));
    end
  end

  // Path row used by each weight position: entry j modulo the path length.
  always_comb begin
    slot_row[0] = row_r;
    for (int j = 1; j < NW; j++) begin
      logic [LW-1:0] slot;
      slot = '0;
      if (path_count != '0) begin
        for (int q = 0; q < NW; q++) begin
          if ((q * int'(path_count)) <= j) begin
            slot = LW'(j - q * int'(path_count));
          end
        end
      end
      slot_row[j] = path_rows[slot];
    end
  end

  // Weight banks: read one row per cycle, write in the clearing pass or on training.
  for (genvar g = 0; g < NW; g++) begin : g_bank
    logic signed [WW-1:0] bank [NUM_ROWS];
    logic [ROW_W-1:0]     raddr;
    logic                 up;

    assign raddr = ctrl.rd_train ? train_addr[g] : row_r;
    if (g == 0) begin : g_bias
      assign up = taken_r;
    end else begin : g_hist
      assign up = (train_bits[g] == taken_r);
    end

    always_ff @(posedge clk) begin
      if (ctrl.clear_wr) begin
        bank[clear_cnt] <= '0;
      end else if (ctrl.wr_train) begin
        bank[train_addr[g]] <= ppbp_pkg::step_weight(rdata[g], up);
      end
      rdata[g] <= bank[raddr];
    end
  end

  // Request latch, training addresses and the result register.
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r   <= command;
      row_r   <= row_in;
      taken_r <= taken;
      sq_r    <= squashed;
    end
    if (ctrl.exec) begin
      res_pt     <= 1'b0;
      res_sum    <= '0;
      res_tr     <= do_train;
      train_bits <= spec_hist;
      for (int j = 0; j < NW; j++) begin
        train_addr[j] <= slot_row[j];
      end
      if (cmd_r == ppbp_pkg::CMD_PREDICT) begin
        res_pt  <= pt;
        res_sum <= y;
      end else if (cmd_r == ppbp_pkg::CMD_RESOLVE) begin
        res_sum <= y;
      end
    end
    if (ctrl.out_load) begin
      predict_taken  <= res_pt;
      perceptron_sum <= res_sum;
      trained        <= res_tr;
    end
  end

  // Path shift line.
  always_ff @(posedge clk) begin
    if (ctrl.exec && ((cmd_r == ppbp_pkg::CMD_PREDICT) || (cmd_r == ppbp_pkg::CMD_UNCOND))) begin
      path_rows[0] <= row_r;
      for (int i = 1; i < NW; i++) begin
        path_rows[i] <= path_rows[i-1];
      end
    end
  end

  // Sums, histories, path length and the clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        spec_sums[i] <= '0;
        comm_sums[i] <= '0;
      end
      spec_hist  <= '0;
      comm_hist  <= '0;
      path_count <= '0;
      clear_cnt  <= '0;
    end else begin
      if (ctrl.clear_wr) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (ctrl.exec) begin
        case (cmd_r)
          ppbp_pkg::CMD_PREDICT: begin
            spec_sums <= spec_adv;
            spec_hist <= {spec_hist[NW-2:0], pt};
            if (path_count != PC_FULL) begin
              path_count <= path_count + 1'b1;
            end
          end
          ppbp_pkg::CMD_UNCOND: begin
            spec_hist <= {spec_hist[NW-2:0], 1'b1};
            if (path_count != PC_FULL) begin
              path_count <= path_count + 1'b1;
            end
          end
          ppbp_pkg::CMD_RESOLVE: begin
            comm_hist <= comm_hist_new;
            comm_sums <= comm_adv;
            if (sq_r) begin
              spec_hist <= comm_hist_new;
              spec_sums <= comm_adv;
            end
          end
          ppbp_pkg::CMD_SQUASH: begin
            spec_hist <= comm_hist;
            spec_sums <= comm_sums;
          end
          ppbp_pkg::CMD_BTBMISS: begin
            comm_hist[0] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/path_perceptron_branch_predictor_core.sv @@
// Flow: a request is accepted in the idle state and passes through the read
// and execute states (and the training read and write states for a resolve
// that trains the weights) before its result goes to the output register.
// A new request is accepted only once the previous result has been loaded
// there. Reset: synchronous; afterwards a clearing pass zeroes every row of
// the weight banks, during which no request is accepted.
// ----------------------------------------------------------------------------
// path_perceptron_branch_predictor_core
// Top level of the path-based perceptron branch predictor with its
// configuration register port.
// ----------------------------------------------------------------------------
module path_perceptron_branch_predictor_core #(
  parameter int HISTORY_LENGTH = ppbp_pkg::HISTORY_LENGTH_DEF,
  parameter int NUM_ROWS       = ppbp_pkg::NUM_ROWS_DEF,
  parameter int ADDR_SHIFT     = ppbp_pkg::ADDR_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ppbp_pkg::CMD_W-1:0]         command,
  input  logic [ppbp_pkg::ADDR_W-1:0]        pc_addr,
  input  logic                               taken,
  input  logic                               squashed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               predict_taken,
  output logic signed [ppbp_pkg::SUM_W-1:0]  perceptron_sum,
  output logic                               trained,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppbp_pkg::PADDR_W-1:0]       paddr,
  input  logic [ppbp_pkg::PDATA_W-1:0]       pwdata,
  output logic [ppbp_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  logic [ppbp_pkg::THRESH_W-1:0] threshold;
  ppbp_pkg::ctrl_t               ctrl;
  ppbp_pkg::stat_t               stat;

  // Register port: always ready, threshold at address zero.
  assign pready = 1'b1;
  assign prdata = (paddr == ppbp_pkg::REG_THRESHOLD) ?
                  ppbp_pkg::PDATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ppbp_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && (paddr == ppbp_pkg::REG_THRESHOLD)) begin
      threshold <= pwdata[ppbp_pkg::THRESH_W-1:0];
    end
  end

  // Sequencer.
  ppbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Datapath.
  ppbp_datapath #(
    .HISTORY_LENGTH (HISTORY_LENGTH),
    .NUM_ROWS       (NUM_ROWS),
    .ADDR_SHIFT     (ADDR_SHIFT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (command),
    .pc_addr        (pc_addr),
    .taken          (taken),
    .squashed       (squashed),
    .threshold      (threshold),
    .predict_taken  (predict_taken),
    .perceptron_sum (perceptron_sum),
    .trained        (trained)
  );

endmodule

@@ tb/sv/tb_path_perceptron_branch_predictor_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_perceptron_branch_predictor_core
// Drives predict, unconditional, resolve, squash and BTB-miss requests into
// the predictor core and checks every response against a typed expectation
// or a local model of the weight table, running sums, histories and path,
// across several threshold settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_path_perceptron_branch_predictor_core;

  localparam int HL = 15;
  localparam int NW = HL + 1;
  localparam int ROWS = 64;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [ppbp_pkg::CMD_W-1:0]  cmd;
    logic [ppbp_pkg::ADDR_W-1:0] addr;
    logic                        tk;
    logic                        sq;
  } req_t;

  typedef struct packed {
    logic                        chk;
    logic                        pt;
    logic [ppbp_pkg::SUM_W-1:0]  sum;
    logic                        tr;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ppbp_pkg::CMD_W-1:0] command = '0;
  logic [ppbp_pkg::ADDR_W-1:0] pc_addr = '0;
  logic taken = 1'b0;
  logic squashed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic predict_taken;
  logic signed [ppbp_pkg::SUM_W-1:0] perceptron_sum;
  logic trained;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ppbp_pkg::PADDR_W-1:0] paddr = '0;
  logic [ppbp_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ppbp_pkg::PDATA_W-1:0] prdata;
  logic pready;

  path_perceptron_branch_predictor_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  int        weights [ROWS][NW];
  int        spec_acc [NW];
  int        comm_acc [NW];
  bit [15:0] spec_hist, comm_hist;
  int        path [NW];
  int        path_len;
  int        theta;

  resp_t     pending_resp [$];
  int        errors = 0;
  int        n_resp = 0;
  int        n_train = 0;
  longint    cycles = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        hold_off = 0;

  function automatic int clamp12(int v);
    return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
  endfunction

  function automatic int nudge(int w, bit up);
    if (up && w < 127) return w + 1;
    if (!up && w > -128) return w - 1;
    return w;
  endfunction

  function automatic void advance(ref int acc [NW], input int row, input bit dir);
    int nx [NW];
    nx[0] = 0;
    for (int j = 1; j <= HL; j++)
      nx[HL-j+1] = clamp12(dir ? acc[HL-j] + weights[row][j] : acc[HL-j] - weights[row][j]);
    acc = nx;
  endfunction

  function automatic void push_row(int row);
    for (int i = NW - 1; i > 0; i--) path[i] = path[i-1];
    path[0] = row;
    if (path_len < NW) path_len++;
  endfunction

  // Works out the response to one request and updates the predictor state.
  function automatic resp_t predict_response(req_t r);
    resp_t o;
    int row, y, mag, p;
    bit [15:0] old_spec;
    o = '0;
    o.chk = 1'b1;
    row = int'((r.addr >> 2) & (ROWS - 1));
    case (r.cmd)
      ppbp_pkg::CMD_PREDICT: begin
        y = clamp12(spec_acc[HL] + weights[row][0]);
        o.pt = (y >= 0);
        o.sum = y[11:0];
        push_row(row);
        advance(spec_acc, row, o.pt);
        spec_hist = {spec_hist[14:0], o.pt};
      end
      ppbp_pkg::CMD_UNCOND: begin
        push_row(row);
        spec_hist = {spec_hist[14:0], 1'b1};
      end
      ppbp_pkg::CMD_RESOLVE: begin
        old_spec = spec_hist;
        y = clamp12(spec_acc[HL] + weights[row][0]);
        o.sum = y[11:0];
        comm_hist = {comm_hist[14:0], r.tk};
        advance(comm_acc, row, r.tk);
        mag = y < 0 ? -y : y;
        if (r.sq || mag <= theta) begin
          o.tr = 1'b1;
          if (r.sq) begin
            spec_hist = comm_hist;
            spec_acc = comm_acc;
          end
          weights[row][0] = nudge(weights[row][0], r.tk);
          for (int j = 1; j <= HL; j++) begin
            p = (path_len == 0) ? 0 : j % path_len;
            weights[path[p]][j] = nudge(weights[path[p]][j], old_spec[j] == r.tk);
          end
        end
      end
      ppbp_pkg::CMD_SQUASH: begin
        spec_hist = comm_hist;
        spec_acc = comm_acc;
      end
      ppbp_pkg::CMD_BTBMISS: comm_hist[0] = 1'b0;
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on response %0d: %s got %0d expected %0d", n_resp, what, got, want);
    errors++;
  endtask

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** path_perceptron_branch_predictor_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Response checking against the oldest expectation.
  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        e = pending_resp.pop_front();
        if (predict_taken !== e.pt) report_mismatch("predict_taken", predict_taken, e.pt);
        if (perceptron_sum !== e.sum)
          report_mismatch("perceptron_sum", perceptron_sum, $signed(e.sum));
        if (trained !== e.tr) report_mismatch("trained", trained, e.tr);
        if (trained) n_train++;
      end
      n_resp++;
    end
  end

  // Offers one request and waits for its acceptance. A typed expectation,
  // when given, replaces the model's answer but the model still steps.
  task automatic send_request(req_t r, resp_t want = '0);
    resp_t e;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.cmd;
    pc_addr <= r.addr;
    taken <= r.tk;
    squashed <= r.sq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_response(r);
    pending_resp.push_back(want.chk ? want : e);
  endtask

  task automatic write_threshold(int v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ppbp_pkg::REG_THRESHOLD; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    theta = v & 12'hFFF;
    @(posedge clk);
  endtask

  // Stops offering requests and waits for every response to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly predicts and resolves, drawn independently; path is always warmed before a resolve.
  function automatic req_t random_request();
    req_t r;
    int k;
    k = $urandom_range(99);
    r.addr = 48'({$urandom, $urandom});
    if (($urandom_range(3)) == 0) r.addr[7:2] = 6'($urandom_range(3));
    r.tk = 1'($urandom);
    r.sq = ($urandom_range(9) == 0);
    if (k < 45) r.cmd = ppbp_pkg::CMD_PREDICT;
    else if (k < 80) r.cmd = ppbp_pkg::CMD_RESOLVE;
    else if (k < 88) r.cmd = ppbp_pkg::CMD_UNCOND;
    else if (k < 93) r.cmd = ppbp_pkg::CMD_SQUASH;
    else if (k < 98) r.cmd = ppbp_pkg::CMD_BTBMISS;
    else r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // Directed rows: extremes and every command; rows with chk clear are
  // checked against the model, the others carry their own expectation.
  req_t  dir_req [20];
  resp_t dir_resp [20];

  initial begin
    for (int i = 0; i < ROWS; i++) for (int j = 0; j < NW; j++) weights[i][j] = 0;
    spec_acc = '{default: 0};
    comm_acc = '{default: 0};
    path = '{default: 0};
    spec_hist = '0; comm_hist = '0; path_len = 0; theta = 54;

    // Warm the path with sixteen entries before any training can happen.
    for (int i = 0; i < 16; i++) begin
      dir_req[i] = '{ppbp_pkg::CMD_PREDICT,
                     (i == 0) ? 48'h0 : ((i == 1) ? '1 : 48'(i * 4)), 1'b0, 1'b0};
      dir_resp[i] = '0;
    end
    dir_resp[0] = '{1'b1, 1'b1, 12'd0, 1'b0};
    dir_req[16] = '{ppbp_pkg::CMD_RESOLVE, '1, 1'b1, 1'b1};
    dir_resp[16] = '0;
    dir_req[17] = '{ppbp_pkg::CMD_BTBMISS, '0, 1'b0, 1'b0};
    dir_resp[17] = '{1'b1, 1'b0, 12'd0, 1'b0};
    dir_req[18] = '{ppbp_pkg::CMD_SQUASH, '0, 1'b1, 1'b1};
    dir_resp[18] = '{1'b1, 1'b0, 12'd0, 1'b0};
    dir_req[19] = '{3'd7, '1, 1'b1, 1'b1};
    dir_resp[19] = '{1'b1, 1'b0, 12'd0, 1'b0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 0; recv_idle = 0;

    foreach (dir_req[i]) send_request(dir_req[i], dir_resp[i]);
    drain();

    // Random phases across threshold settings and idling patterns.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(0);
        1: write_threshold(4095);
        2: write_threshold(54);
        3: write_threshold($urandom_range(1, 300));
        default: write_threshold(200);
      endcase
      if (ph < 2) begin send_idle = 19; recv_idle = 69; end
      else if (ph < 4) begin send_idle = 69; recv_idle = 19; end
      else begin send_idle = 0; recv_idle = 0; end
      if (ph == 4) hold_off = 300;
      repeat (100) send_request(random_request());
      drain();
    end

    $display("run covered %0d responses, %0d of them training resolves", n_resp, n_train);
    $display("five threshold settings including 0 and 4095, mixed idling and a long stall");
    if (errors == 0) begin
      $display("** path_perceptron_branch_predictor_core: PASSED **");
    end else begin
      $display("** path_perceptron_branch_predictor_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ppbp_pkg.sv
hdl/ppbp_ctrl.sv
hdl/ppbp_datapath.sv
hdl/path_perceptron_branch_predictor_core.sv
tb/sv/tb_path_perceptron_branch_predictor_core.sv
